// ===== design/t2h_pkg.sv =====
// Shared types, string tables and helpers for the text-to-HTML transcoder.
// Used by the front classifier, the plan queue and the back sequencer.
package t2h_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned StrBits    = 256;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChReturn  = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] CyrLead0  = 8'hD0;
  localparam logic [7:0] CyrLead1  = 8'hD1;
  localparam logic [7:0] CyrLow    = 8'd192;
  localparam logic [7:0] CyrHigh   = 8'd240;
  localparam logic [7:0] CyrOff0   = 8'd48;
  localparam logic [7:0] CyrOff1   = 8'd112;

  localparam logic [2:0] ColMax = 3'd7;

  localparam logic [StrBits-1:0] SGrey   = StrBits'("<span style='color:#888888;'>");
  localparam logic [StrBits-1:0] SBlue   = StrBits'("<span style='color:#0055ff;'>");
  localparam logic [StrBits-1:0] STeal   = StrBits'("<span style='color:#008080;'>");
  localparam logic [StrBits-1:0] SMaroon = StrBits'("<span style='color:#800000;'>");
  localparam logic [StrBits-1:0] SClose  = StrBits'("</span>");
  localparam logic [StrBits-1:0] SNbsp   = StrBits'("&nbsp;");
  localparam logic [StrBits-1:0] SBreak  = StrBits'("<br>\n");
  localparam logic [StrBits-1:0] SLt     = StrBits'("&lt;");
  localparam logic [StrBits-1:0] SGt     = StrBits'("&gt;");
  localparam logic [StrBits-1:0] SAmp    = StrBits'("&amp;");
  localparam logic [StrBits-1:0] STail   = StrBits'("</div></body></html>");

  typedef enum logic [3:0] {
    STR_NONE,
    STR_GREY,
    STR_BLUE,
    STR_TEAL,
    STR_MAROON,
    STR_CLOSE,
    STR_NBSP,
    STR_BREAK,
    STR_LT,
    STR_GT,
    STR_AMP,
    STR_TAIL
  } str_id_e;

  typedef enum logic [1:0] {
    MID_NONE,
    MID_RAW1,
    MID_RAW2,
    MID_STR
  } mid_kind_e;

  typedef struct packed {
    str_id_e    head;
    mid_kind_e  mid;
    str_id_e    mid_str;
    logic [7:0] b0;
    logic [7:0] b1;
    str_id_e    tail;
  } plan_t;

  typedef struct packed {
    logic [2:0] column;
    logic       lead;
  } front_st_t;

  function automatic logic [4:0] str_len(str_id_e id);
    logic [4:0] len;
    case (id)
      STR_GREY, STR_BLUE, STR_TEAL, STR_MAROON: len = 5'd29;
      STR_CLOSE: len = 5'd7;
      STR_NBSP:  len = 5'd6;
      STR_BREAK: len = 5'd5;
      STR_LT:    len = 5'd4;
      STR_GT:    len = 5'd4;
      STR_AMP:   len = 5'd5;
      STR_TAIL:  len = 5'd20;
      default:   len = 5'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] str_byte(str_id_e id, logic [4:0] idx);
    logic [StrBits-1:0] s;
    logic [4:0]         pos;
    case (id)
      STR_GREY:   s = SGrey;
      STR_BLUE:   s = SBlue;
      STR_TEAL:   s = STeal;
      STR_MAROON: s = SMaroon;
      STR_CLOSE:  s = SClose;
      STR_NBSP:   s = SNbsp;
      STR_BREAK:  s = SBreak;
      STR_LT:     s = SLt;
      STR_GT:     s = SGt;
      STR_AMP:    s = SAmp;
      STR_TAIL:   s = STail;
      default:    s = '0;
    endcase
    pos = str_len(id) - 5'd1 - idx;
    return s[{pos, 3'b000} +: 8];
  endfunction

endpackage

// ===== design/t2h_in_if.sv =====
// Input channel of the transcoder: valid/ready with one text byte or end of stream.
// Standalone interface, no dependencies.
interface t2h_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] text_byte;

  modport source (output valid, output cmd, output text_byte, input ready);
  modport sink   (input valid, input cmd, input text_byte, output ready);
endinterface

// ===== design/t2h_out_if.sv =====
// Output channel of the transcoder: valid/ready with one HTML byte per transfer.
// Standalone interface, no dependencies.
interface t2h_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] html_byte;
  logic       run_last;

  modport source (output valid, output html_byte, output run_last, input ready);
  modport sink   (input valid, input html_byte, input run_last, output ready);
endinterface

// ===== design/text_to_colored_html_transcoder.sv =====
// Text-to-HTML transcoder: each input transfer carries one text byte or the end
// of stream; the block answers with that item's HTML bytes, one byte per output
// transfer, the final one flagged by run_last. An item expands to no bytes for a
// carriage return and to 5 to 42 bytes otherwise, sent through the one-byte output
// register of the back sequencer. The front takes a new item in any cycle the
// two-entry plan queue has room, also while output is stalled. encoding_mode is to be
// written through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
module text_to_colored_html_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  t2h_in_if.sink     in_s,
  t2h_out_if.source  out_m
);

  logic               [1:0] mode_q;
  logic                     push;
  logic                     full;
  logic                     pop;
  logic                     plan_valid;
  t2h_pkg::plan_t           plan_w;
  t2h_pkg::plan_t           plan_r;
  t2h_pkg::front_st_t       st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  t2h_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_s),
    .mode_i (mode_q),
    .full_i (full),
    .push_o (push),
    .plan_o (plan_w),
    .st_o   (st)
  );

  t2h_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .plan_i  (plan_w),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (plan_valid),
    .plan_o  (plan_r)
  );

  t2h_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (plan_valid),
    .plan_i       (plan_r),
    .pop_o        (pop),
    .out_m        (out_m)
  );

  a_eos_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.valid && in_s.ready && in_s.cmd |=> st.column == '0 && !st.lead)
    else $error("end of stream did not clear column and lead state");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !in_s.ready)
    else $error("input ready while plan queue full");

  a_pop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_m.valid && out_m.run_last)
    else $error("plan retired without a final byte");

  a_pop_needs_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> plan_valid)
    else $error("plan queue popped while empty");

endmodule

// ===== design/t2h_front.sv =====
// Front classifier: accepts input transfers, tracks column and pending lead byte,
// and builds an emission plan. Depends on t2h_pkg and t2h_in_if.
module t2h_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  t2h_in_if.sink              in_s,
  input  logic [1:0]          mode_i,
  input  logic                full_i,
  output logic                push_o,
  output t2h_pkg::plan_t      plan_o,
  output t2h_pkg::front_st_t  st_o
);

  logic [2:0] col_q, col_d;
  logic       lead_q, lead_d;
  logic       accept;
  logic       emit;
  logic [7:0] c;
  logic       is_esc;
  logic       adv;

  assign in_s.ready = !full_i;
  assign accept     = in_s.valid && in_s.ready;
  assign c          = in_s.text_byte;
  assign is_esc     = (c == t2h_pkg::ChSpace) || (c == t2h_pkg::ChLt) ||
                      (c == t2h_pkg::ChGt) || (c == t2h_pkg::ChAmp);

  always_comb begin
    plan_o.head    = t2h_pkg::STR_NONE;
    plan_o.mid     = t2h_pkg::MID_NONE;
    plan_o.mid_str = t2h_pkg::STR_NONE;
    plan_o.b0      = c;
    plan_o.b1      = c;
    plan_o.tail    = t2h_pkg::STR_NONE;
    emit           = 1'b1;
    adv            = 1'b0;
    col_d          = col_q;
    lead_d         = lead_q;
    if (in_s.cmd) begin
      plan_o.head = lead_q ? t2h_pkg::STR_CLOSE : t2h_pkg::STR_NONE;
      plan_o.tail = t2h_pkg::STR_TAIL;
      col_d       = '0;
      lead_d      = 1'b0;
    end else if (lead_q) begin
      plan_o.mid  = t2h_pkg::MID_RAW1;
      plan_o.tail = t2h_pkg::STR_CLOSE;
      adv         = 1'b1;
      lead_d      = 1'b0;
    end else if (c == t2h_pkg::ChNewline) begin
      plan_o.head = (col_q == '0) ? t2h_pkg::STR_NBSP : t2h_pkg::STR_NONE;
      plan_o.tail = t2h_pkg::STR_BREAK;
      col_d       = '0;
    end else if (c == t2h_pkg::ChReturn) begin
      emit = 1'b0;
    end else begin
      if (col_q <= 3'd2) begin
        plan_o.head = t2h_pkg::STR_GREY;
      end else if (col_q <= 3'd6) begin
        plan_o.head = t2h_pkg::STR_BLUE;
      end else if (c >= t2h_pkg::ChZero && c <= t2h_pkg::ChNine) begin
        plan_o.head = t2h_pkg::STR_TEAL;
      end else begin
        plan_o.head = t2h_pkg::STR_MAROON;
      end
      plan_o.tail = t2h_pkg::STR_CLOSE;
      adv         = 1'b1;
      if (is_esc) begin
        plan_o.mid = t2h_pkg::MID_STR;
        case (c)
          t2h_pkg::ChSpace: plan_o.mid_str = t2h_pkg::STR_NBSP;
          t2h_pkg::ChLt:    plan_o.mid_str = t2h_pkg::STR_LT;
          t2h_pkg::ChGt:    plan_o.mid_str = t2h_pkg::STR_GT;
          default:          plan_o.mid_str = t2h_pkg::STR_AMP;
        endcase
      end else if (mode_i == 2'd0) begin
        plan_o.mid = t2h_pkg::MID_RAW1;
        if (c[7:5] == 3'b110) begin
          plan_o.tail = t2h_pkg::STR_NONE;
          adv         = 1'b0;
          lead_d      = 1'b1;
        end else if (c[7:6] == 2'b10) begin
          adv = 1'b0;
        end
      end else if (c >= t2h_pkg::CyrLow) begin
        plan_o.mid = t2h_pkg::MID_RAW2;
        if (c < t2h_pkg::CyrHigh) begin
          plan_o.b0 = t2h_pkg::CyrLead0;
          plan_o.b1 = c - t2h_pkg::CyrOff0;
        end else begin
          plan_o.b0 = t2h_pkg::CyrLead1;
          plan_o.b1 = c - t2h_pkg::CyrOff1;
        end
      end else begin
        plan_o.mid = t2h_pkg::MID_RAW1;
      end
    end
    if (adv && col_q != t2h_pkg::ColMax) begin
      col_d = col_q + 3'd1;
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      lead_q <= 1'b0;
    end else if (accept) begin
      col_q  <= col_d;
      lead_q <= lead_d;
    end
  end

  assign st_o.column = col_q;
  assign st_o.lead   = lead_q;

endmodule

// ===== design/t2h_queue.sv =====
// Short plan queue between the front classifier and the back sequencer.
// Depends on t2h_pkg.
module t2h_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  t2h_pkg::plan_t  plan_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output t2h_pkg::plan_t  plan_o
);

  t2h_pkg::plan_t                   mem_q [t2h_pkg::QueueDepth];
  logic [t2h_pkg::QPtrW-1:0]        wptr_q, rptr_q;
  logic [t2h_pkg::QCntW-1:0]        cnt_q, cnt_d;

  assign full_o  = cnt_q == t2h_pkg::QCntW'(t2h_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign plan_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == t2h_pkg::QPtrW'(t2h_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == t2h_pkg::QPtrW'(t2h_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/t2h_back.sv =====
// Back sequencer: walks the head, middle and tail segments of each plan and
// emits one HTML byte per transfer. Depends on t2h_pkg and t2h_out_if.
module t2h_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            plan_valid_i,
  input  t2h_pkg::plan_t  plan_i,
  output logic            pop_o,
  t2h_out_if.source       out_m
);

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_MID,
    PH_TAIL
  } phase_e;

  phase_e     phase_q, eff, nxt;
  logic [4:0] idx_q;
  logic [4:0] seg_len;
  logic [7:0] seg_byte;
  logic       later;
  logic       p0, p1, p2;
  logic       seg_end, last, load;
  logic       ov_q, last_q;
  logic [7:0] byte_q;

  assign p0 = plan_i.head != t2h_pkg::STR_NONE;
  assign p1 = plan_i.mid != t2h_pkg::MID_NONE;
  assign p2 = plan_i.tail != t2h_pkg::STR_NONE;

  always_comb begin
    case (phase_q)
      PH_HEAD: eff = p0 ? PH_HEAD : (p1 ? PH_MID : PH_TAIL);
      PH_MID:  eff = p1 ? PH_MID : PH_TAIL;
      default: eff = PH_TAIL;
    endcase
    case (eff)
      PH_HEAD: nxt = PH_MID;
      default: nxt = PH_TAIL;
    endcase
  end

  always_comb begin
    case (eff)
      PH_HEAD: begin
        seg_len  = t2h_pkg::str_len(plan_i.head);
        seg_byte = t2h_pkg::str_byte(plan_i.head, idx_q);
        later    = p1 || p2;
      end
      PH_MID: begin
        later = p2;
        case (plan_i.mid)
          t2h_pkg::MID_RAW2: begin
            seg_len  = 5'd2;
            seg_byte = idx_q[0] ? plan_i.b1 : plan_i.b0;
          end
          t2h_pkg::MID_STR: begin
            seg_len  = t2h_pkg::str_len(plan_i.mid_str);
            seg_byte = t2h_pkg::str_byte(plan_i.mid_str, idx_q);
          end
          default: begin
            seg_len  = 5'd1;
            seg_byte = plan_i.b0;
          end
        endcase
      end
      default: begin
        seg_len  = t2h_pkg::str_len(plan_i.tail);
        seg_byte = t2h_pkg::str_byte(plan_i.tail, idx_q);
        later    = 1'b0;
      end
    endcase
  end

  assign seg_end = idx_q == seg_len - 5'd1;
  assign last    = seg_end && !later;
  assign load    = plan_valid_i && (!ov_q || out_m.ready);
  assign pop_o   = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      byte_q  <= '0;
      last_q  <= 1'b0;
    end else if (load) begin
      ov_q   <= 1'b1;
      byte_q <= seg_byte;
      last_q <= last;
      if (last) begin
        phase_q <= PH_HEAD;
        idx_q   <= '0;
      end else if (seg_end) begin
        phase_q <= nxt;
        idx_q   <= '0;
      end else begin
        phase_q <= eff;
        idx_q   <= idx_q + 5'd1;
      end
    end else if (out_m.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign out_m.valid     = ov_q;
  assign out_m.html_byte = byte_q;
  assign out_m.run_last  = last_q;

endmodule
